// File: rtl/weekly_schedule_alarm_with_quiet_window_unit_macros.svh
// Assertion helpers used by the top-level unit to check its own behavior.
// Each macro expects clk_i and rst_ni in scope.
`ifndef WEEKLY_SCHEDULE_ALARM_WITH_QUIET_WINDOW_UNIT_MACROS_SVH
`define WEEKLY_SCHEDULE_ALARM_WITH_QUIET_WINDOW_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WSA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsa_pkg.sv
package wsa_pkg;

  typedef enum logic [2:0] {
    EV_QUIET_ON  = 3'd0,
    EV_QUIET_OFF = 3'd1,
    EV_START     = 3'd2,
    EV_EXPIRED   = 3'd3,
    EV_DONE      = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    REG_QUIET_ENABLE       = 3'd0,
    REG_QUIET_START_HOUR   = 3'd1,
    REG_QUIET_START_MINUTE = 3'd2,
    REG_QUIET_END_HOUR     = 3'd3,
    REG_QUIET_END_MINUTE   = 3'd4,
    REG_QUIET_CROSSES      = 3'd5,
    REG_SCHEDULE_ENABLE    = 3'd6,
    REG_ENTRIES_IN_USE     = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgDataW = 6;

  typedef struct packed {
    logic       quiet_enable;
    logic [4:0] quiet_start_hour;
    logic [5:0] quiet_start_minute;
    logic [4:0] quiet_end_hour;
    logic [5:0] quiet_end_minute;
    logic       quiet_crosses_midnight;
    logic       schedule_enable;
    logic [3:0] entries_in_use;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] days;
    logic [4:0] hour;
    logic [5:0] minute;
  } entry_t;

  typedef enum logic [2:0] {
    UOP_LOCK,
    UOP_QUIET,
    UOP_SCAN_INIT,
    UOP_ENTRY_START,
    UOP_ENTRY_EXPIRE,
    UOP_DONE,
    UOP_WRITE
  } uop_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_WRITE,
    J_NOSCAN,
    J_MORE,
    J_END
  } jcond_e;

  typedef logic [2:0] upc_t;

  typedef struct packed {
    uop_e   op;
    jcond_e cond;
    upc_t   target;
  } uword_t;

  localparam upc_t PcEntry = 3'd3;
  localparam upc_t PcDone  = 3'd5;
  localparam upc_t PcWrite = 3'd6;

  // Microprogram. A write item branches away at the first step, which then
  // acts only for ticks.
  function automatic uword_t ucode(upc_t pc);
    uword_t w;
    case (pc)
      3'd0:    w = '{op: UOP_LOCK,         cond: J_WRITE,  target: PcWrite};
      3'd1:    w = '{op: UOP_QUIET,        cond: J_NEXT,   target: PcDone};
      3'd2:    w = '{op: UOP_SCAN_INIT,    cond: J_NOSCAN, target: PcDone};
      3'd3:    w = '{op: UOP_ENTRY_START,  cond: J_NEXT,   target: PcDone};
      3'd4:    w = '{op: UOP_ENTRY_EXPIRE, cond: J_MORE,   target: PcEntry};
      3'd5:    w = '{op: UOP_DONE,         cond: J_END,    target: PcDone};
      3'd6:    w = '{op: UOP_WRITE,        cond: J_ALWAYS, target: PcDone};
      default: w = '{op: UOP_DONE,         cond: J_END,    target: PcDone};
    endcase
    return w;
  endfunction

  typedef struct packed {
    logic load;
    logic run;
    uop_e op;
  } ctrl_t;

  typedef struct packed {
    logic is_write;
    logic no_scan;
    logic more;
  } stat_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

endpackage

// File: rtl/wsa_useq.sv
module wsa_useq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  wsa_pkg::stat_t stat_i,
  output logic           busy_o,
  output wsa_pkg::ctrl_t ctrl_o
);

  wsa_pkg::seq_state_e state_q, state_d;
  wsa_pkg::upc_t       pc_q, pc_d;
  wsa_pkg::uword_t     uw;
  logic                take_jump;

  assign uw = wsa_pkg::ucode(pc_q);

  always_comb begin
    case (uw.cond)
      wsa_pkg::J_ALWAYS: take_jump = 1'b1;
      wsa_pkg::J_WRITE:  take_jump = stat_i.is_write;
      wsa_pkg::J_NOSCAN: take_jump = stat_i.no_scan;
      wsa_pkg::J_MORE:   take_jump = stat_i.more;
      default:           take_jump = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      wsa_pkg::SEQ_IDLE: begin
        pc_d = '0;
        if (start_i) begin
          state_d = wsa_pkg::SEQ_RUN;
        end
      end
      wsa_pkg::SEQ_RUN: begin
        if (uw.cond == wsa_pkg::J_END) begin
          state_d = wsa_pkg::SEQ_IDLE;
          pc_d    = '0;
        end else if (take_jump) begin
          pc_d = uw.target;
        end else begin
          pc_d = pc_q + 3'd1;
        end
      end
    endcase
  end

  always_comb begin
    busy_o      = 1'b0;
    ctrl_o.load = 1'b0;
    ctrl_o.run  = 1'b0;
    ctrl_o.op   = uw.op;
    unique case (state_q)
      wsa_pkg::SEQ_IDLE: begin
        ctrl_o.load = start_i;
      end
      wsa_pkg::SEQ_RUN: begin
        busy_o     = 1'b1;
        ctrl_o.run = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsa_pkg::SEQ_IDLE;
      pc_q    <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

endmodule

// File: rtl/wsa_dpath.sv
module wsa_dpath #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned LOCKOUT_MS  = 60000
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  wsa_pkg::ctrl_t ctrl_i,
  input  wsa_pkg::cfg_t  cfg_i,
  input  logic           action_i,
  input  logic [2:0]     now_weekday_i,
  input  logic [4:0]     now_hour_i,
  input  logic [5:0]     now_minute_i,
  input  logic [31:0]    now_ms_i,
  input  logic [2:0]     slot_i,
  input  logic           slot_valid_i,
  input  logic [6:0]     slot_days_i,
  input  logic [4:0]     slot_hour_i,
  input  logic [5:0]     slot_minute_i,
  output wsa_pkg::stat_t stat_o,
  output logic           out_valid_o,
  output logic [2:0]     event_kind_o,
  output logic [2:0]     event_slot_o,
  output logic           last_o
);

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = (IW > 4) ? IW : 4;

  // Latched item.
  logic        action_q;
  logic [2:0]  wday_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [31:0] ms_q;
  logic [2:0]  slot_q;
  wsa_pkg::entry_t wr_entry_q;

  wsa_pkg::entry_t table_q [MAX_ENTRIES];

  logic          quiet_active_q, quiet_active_d;
  logic          locked_q, locked_d;
  logic [31:0]   lock_time_q, lock_time_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          hit_q, hit_d;

  logic            emit_v, emit_last;
  wsa_pkg::event_e emit_kind, kind_q;
  logic [2:0]      emit_slot, slot_out_q;
  logic            last_q, out_valid_q;

  logic            wr_en, clr_en;
  logic [CW-1:0]   slot_w, count_w;
  logic [3:0]      count;
  wsa_pkg::entry_t cur;
  logic [6:0]      day_bit;
  logic            now_quiet, entry_quiet, match;
  logic [31:0]     elapsed;

  function automatic logic in_window(logic [4:0] h, logic [5:0] m, wsa_pkg::cfg_t c);
    logic [10:0] t, s, e;
    t = {h, m};
    s = {c.quiet_start_hour, c.quiet_start_minute};
    e = {c.quiet_end_hour, c.quiet_end_minute};
    if (c.quiet_crosses_midnight) begin
      return (t >= s) || (t <= e);
    end
    return (s <= t) && (t <= e);
  endfunction

  // Sunday sits in the top mask bit; weekday seven selects no day.
  always_comb begin
    case (wday_q)
      3'd0:    day_bit = 7'h40;
      3'd7:    day_bit = 7'h00;
      default: day_bit = 7'(7'h01 << (wday_q - 3'd1));
    endcase
  end

  assign count   = (32'(cfg_i.entries_in_use) > MAX_ENTRIES) ? 4'(MAX_ENTRIES)
                                                             : cfg_i.entries_in_use;
  assign count_w = CW'(count);
  assign slot_w  = CW'(slot_q);
  assign cur     = table_q[idx_q[IW-1:0]];
  assign elapsed = ms_q - lock_time_q;

  assign now_quiet   = in_window(hour_q, minute_q, cfg_i);
  assign entry_quiet = cfg_i.quiet_enable && in_window(cur.hour, cur.minute, cfg_i);
  assign match = cur.valid && !entry_quiet &&
                 ((cur.days == 7'd0) || ((cur.days & day_bit) != 7'd0)) &&
                 (cur.hour == hour_q) && (cur.minute == minute_q);

  assign stat_o.is_write = action_q;
  assign stat_o.no_scan  = !cfg_i.schedule_enable || (count == 4'd0);
  assign stat_o.more     = (idx_q + CW'(1)) < count_w;

  always_comb begin
    quiet_active_d = quiet_active_q;
    locked_d       = locked_q;
    lock_time_d    = lock_time_q;
    idx_d          = idx_q;
    hit_d          = hit_q;
    emit_v         = 1'b0;
    emit_kind      = wsa_pkg::EV_DONE;
    emit_slot      = 3'd0;
    emit_last      = 1'b0;
    wr_en          = 1'b0;
    clr_en         = 1'b0;
    if (ctrl_i.run) begin
      case (ctrl_i.op)
        wsa_pkg::UOP_LOCK: begin
          if (!action_q && (elapsed > 32'(LOCKOUT_MS))) begin
            locked_d    = 1'b0;
            lock_time_d = ms_q;
          end
        end
        wsa_pkg::UOP_QUIET: begin
          if (cfg_i.quiet_enable && now_quiet && !quiet_active_q) begin
            emit_v         = 1'b1;
            emit_kind      = wsa_pkg::EV_QUIET_ON;
            quiet_active_d = 1'b1;
          end else if ((!now_quiet || !cfg_i.quiet_enable) && quiet_active_q) begin
            emit_v         = 1'b1;
            emit_kind      = wsa_pkg::EV_QUIET_OFF;
            quiet_active_d = 1'b0;
          end
        end
        wsa_pkg::UOP_SCAN_INIT: begin
          idx_d = '0;
        end
        wsa_pkg::UOP_ENTRY_START: begin
          hit_d = match;
          if (match && !locked_q) begin
            emit_v      = 1'b1;
            emit_kind   = wsa_pkg::EV_START;
            emit_slot   = idx_q[2:0];
            locked_d    = 1'b1;
            lock_time_d = ms_q;
          end
        end
        wsa_pkg::UOP_ENTRY_EXPIRE: begin
          if (hit_q && (cur.days == 7'd0)) begin
            emit_v    = 1'b1;
            emit_kind = wsa_pkg::EV_EXPIRED;
            emit_slot = idx_q[2:0];
            clr_en    = 1'b1;
          end
          idx_d = idx_q + CW'(1);
        end
        wsa_pkg::UOP_DONE: begin
          emit_v    = 1'b1;
          emit_kind = wsa_pkg::EV_DONE;
          emit_last = 1'b1;
        end
        wsa_pkg::UOP_WRITE: begin
          wr_en = (32'(slot_q) < MAX_ENTRIES);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      action_q   <= action_i;
      wday_q     <= now_weekday_i;
      hour_q     <= now_hour_i;
      minute_q   <= now_minute_i;
      ms_q       <= now_ms_i;
      slot_q     <= slot_i;
      wr_entry_q <= '{valid: slot_valid_i, days: slot_days_i,
                      hour: slot_hour_i, minute: slot_minute_i};
    end
    if (wr_en) begin
      table_q[slot_w[IW-1:0]] <= wr_entry_q;
    end else if (clr_en) begin
      table_q[idx_q[IW-1:0]].valid <= 1'b0;
    end
    idx_q      <= idx_d;
    hit_q      <= hit_d;
    kind_q     <= emit_kind;
    slot_out_q <= emit_slot;
    last_q     <= emit_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_active_q <= 1'b0;
      locked_q       <= 1'b0;
      lock_time_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      quiet_active_q <= quiet_active_d;
      locked_q       <= locked_d;
      lock_time_q    <= lock_time_d;
      out_valid_q    <= emit_v;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_kind_o = kind_q;
  assign event_slot_o = slot_out_q;
  assign last_o       = last_q;

endmodule

// File: rtl/weekly_schedule_alarm_with_quiet_window_unit.sv
// Channel   Handshake              Payload
// -------   ---------------------  ---------------------------------------------
// item in   start_i while !busy_o  action_i, now_*_i, slot_*_i
// result    out_valid_o strobe     event_kind_o, event_slot_o, last_o
// config    cfg_we_i               cfg_idx_i, cfg_data_i
//
// busy_o stays high while the microprogram runs: a write item takes the lock, write and done steps;
// a tick takes the lock, quiet, scan-init and done steps, and two steps per entry scanned.
// Each result appears in the cycle after the step that makes it, for one cycle only.
// The next item may be accepted while the done result is still on the outputs.
// Reset clears the lockout, quiet state and configuration; table contents are
// undefined until written.
`include "weekly_schedule_alarm_with_quiet_window_unit_macros.svh"

module weekly_schedule_alarm_with_quiet_window_unit #(
  parameter int unsigned MAX_ENTRIES = 8,
  parameter int unsigned LOCKOUT_MS  = 60000
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         action_i,
  input  logic [2:0]                   now_weekday_i,
  input  logic [4:0]                   now_hour_i,
  input  logic [5:0]                   now_minute_i,
  input  logic [31:0]                  now_ms_i,
  input  logic [2:0]                   slot_i,
  input  logic                         slot_valid_i,
  input  logic [6:0]                   slot_days_i,
  input  logic [4:0]                   slot_hour_i,
  input  logic [5:0]                   slot_minute_i,
  input  logic                         cfg_we_i,
  input  logic [2:0]                   cfg_idx_i,
  input  logic [wsa_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         out_valid_o,
  output logic [2:0]                   event_kind_o,
  output logic [2:0]                   event_slot_o,
  output logic                         last_o
);

  wsa_pkg::cfg_t  cfg_q, cfg_d;
  wsa_pkg::ctrl_t ctrl;
  wsa_pkg::stat_t stat;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wsa_pkg::cfg_reg_e'(cfg_idx_i))
        wsa_pkg::REG_QUIET_ENABLE:       cfg_d.quiet_enable = cfg_data_i[0];
        wsa_pkg::REG_QUIET_START_HOUR:   cfg_d.quiet_start_hour = cfg_data_i[4:0];
        wsa_pkg::REG_QUIET_START_MINUTE: cfg_d.quiet_start_minute = cfg_data_i[5:0];
        wsa_pkg::REG_QUIET_END_HOUR:     cfg_d.quiet_end_hour = cfg_data_i[4:0];
        wsa_pkg::REG_QUIET_END_MINUTE:   cfg_d.quiet_end_minute = cfg_data_i[5:0];
        wsa_pkg::REG_QUIET_CROSSES:      cfg_d.quiet_crosses_midnight = cfg_data_i[0];
        wsa_pkg::REG_SCHEDULE_ENABLE:    cfg_d.schedule_enable = cfg_data_i[0];
        wsa_pkg::REG_ENTRIES_IN_USE:     cfg_d.entries_in_use = cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wsa_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .busy_o (busy_o),
    .ctrl_o (ctrl)
  );

  wsa_dpath #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .LOCKOUT_MS (LOCKOUT_MS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cfg_i        (cfg_q),
    .action_i     (action_i),
    .now_weekday_i(now_weekday_i),
    .now_hour_i   (now_hour_i),
    .now_minute_i (now_minute_i),
    .now_ms_i     (now_ms_i),
    .slot_i       (slot_i),
    .slot_valid_i (slot_valid_i),
    .slot_days_i  (slot_days_i),
    .slot_hour_i  (slot_hour_i),
    .slot_minute_i(slot_minute_i),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .event_kind_o (event_kind_o),
    .event_slot_o (event_slot_o),
    .last_o       (last_o)
  );

  `WSA_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o, "accepted item did not start")
  `WSA_ASSERT_SAME(a_last_done, out_valid_o && last_o, event_kind_o == wsa_pkg::EV_DONE,
                   "final result is not done")
  `WSA_ASSERT_SAME(a_done_idle, out_valid_o && last_o, !busy_o,
                   "sequencer still busy when done is shown")
  `WSA_ASSERT_SAME(a_idle_quiet, out_valid_o && !busy_o, last_o,
                   "non-final result while idle")

endmodule
